>>> src/coc_pkg.sv
// Shared constants and types for the collective order checker.
`timescale 1ns / 1ps

package coc_pkg;

   localparam int unsigned MAX_RANKS_DEF = 32;

   localparam int unsigned GROUP_SIZE_W = 6;
   localparam int unsigned RANK_W       = 16;
   localparam int unsigned SEQ_W        = 64;
   localparam int unsigned BYTES_W      = 48;

   localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = GROUP_SIZE_W'(1);

   typedef logic [GROUP_SIZE_W-1:0] group_size_type;
   typedef logic [RANK_W-1:0]       rank_type;
   typedef logic [SEQ_W-1:0]        seq_type;
   typedef logic [BYTES_W-1:0]      bytes_type;

endpackage

>>> src/coc_if.sv
// Valid/ready channel interfaces for log entries, verdicts and the group size register.
`timescale 1ns / 1ps

interface coc_req_if;
   import coc_pkg::*;

   logic      valid;
   logic      ready;
   rank_type  rank;
   seq_type   sequence_req;
   bytes_type byte_count;
   logic      is_begin;
   logic      last_entry;

   modport source (output valid, output rank, output sequence_req, output byte_count,
                   output is_begin, output last_entry, input ready);
   modport sink   (input valid, input rank, input sequence_req, input byte_count,
                   input is_begin, input last_entry, output ready);
endinterface

interface coc_rsp_if;
   logic valid;
   logic ready;
   logic consistent;

   modport source (output valid, output consistent, input ready);
   modport sink   (input valid, input consistent, output ready);
endinterface

interface coc_csr_if;
   import coc_pkg::*;

   logic           valid;
   logic           ready;
   group_size_type group_size;

   modport source (output valid, output group_size, input ready);
   modport sink   (input valid, input group_size, output ready);
endinterface

>>> src/collective_order_checker.sv
// Top level: collective order checker over a stream of log entries.
// A verdict reaches rsp through the entry register and then the result register.
// Throughput: one entry per cycle; the entry register advances whenever the result
// register is free or being drained, so stalls on rsp only hold back last entries.
// Reset (synchronous, active high) clears group state, the sticky failure flag and both
// valid flags, and sets group_size to 1. The csr channel is always ready.
`timescale 1ns / 1ps

module collective_order_checker #(
   parameter int unsigned MAX_RANKS = coc_pkg::MAX_RANKS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   coc_req_if.sink   req_ch,
   coc_rsp_if.source rsp_ch,
   coc_csr_if.sink   csr_ch
);
   import coc_pkg::*;

   // slot never exceeds MAX_RANKS-1, rank index only used when rank < MAX_RANKS
   localparam int unsigned IDX_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
   localparam logic [MAX_RANKS-1:0] ONE_BIT = MAX_RANKS'(1);

   // ---------------- configuration ----------------
   group_size_type group_size_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= GROUP_SIZE_RESET;
      end else if (csr_ch.valid) begin
         group_size_ff <= csr_ch.group_size;
      end
   end

   // ---------------- entry register ----------------
   logic      in_vld_ff, in_vld_in;
   rank_type  in_rank_ff;
   seq_type   in_seq_ff;
   bytes_type in_bytes_ff;
   logic      in_begin_ff;
   logic      in_last_ff;

   logic      req_xfer;
   logic      fire;         // entry in the register is consumed this cycle

   // ---------------- group state ----------------
   logic [IDX_W-1:0]     slot_ff, slot_in;
   seq_type              ref_seq_ff;
   bytes_type            ref_bytes_ff;
   logic                 ref_begin_ff;
   logic [MAX_RANKS-1:0] seen_ff, seen_in;
   logic                 failed_ff, failed_in;

   // ---------------- result register ----------------
   logic out_vld_ff, out_vld_in;
   logic out_consistent_ff;

   // ---------------- per-entry checks ----------------
   logic                 bad_size;
   logic                 first;
   seq_type              eff_seq;
   bytes_type            eff_bytes;
   logic                 eff_begin;
   logic [MAX_RANKS-1:0] eff_seen;
   logic                 mismatch;
   logic                 rank_ok;
   logic [MAX_RANKS-1:0] rank_onehot;
   logic                 dup;
   logic                 failed_next;
   logic                 closing;
   logic                 verdict;

   // last entries wait for a free result register; others pass straight through
   assign fire     = in_vld_ff && (!in_last_ff || !out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || fire;
   assign req_xfer = req_ch.valid && req_ch.ready;

   always_comb begin
      bad_size = (group_size_ff == '0) || (32'(group_size_ff) > MAX_RANKS);
      first    = (slot_ff == '0);

      // first entry of a group is its own reference
      eff_seq   = first ? in_seq_ff   : ref_seq_ff;
      eff_bytes = first ? in_bytes_ff : ref_bytes_ff;
      eff_begin = first ? in_begin_ff : ref_begin_ff;
      eff_seen  = first ? '0          : seen_ff;

      mismatch = (in_seq_ff != eff_seq) || (in_bytes_ff != eff_bytes)
                 || (in_begin_ff != eff_begin);
      rank_ok  = (32'(in_rank_ff) < 32'(group_size_ff)) && (32'(in_rank_ff) < MAX_RANKS);
      rank_onehot = rank_ok ? (ONE_BIT << in_rank_ff[IDX_W-1:0]) : '0;
      dup      = |(eff_seen & rank_onehot);

      failed_next = failed_ff || bad_size || mismatch || !rank_ok || dup;
      closing     = bad_size || ((32'(slot_ff) + 32'd1) >= 32'(group_size_ff));
      verdict     = !failed_next && closing && !bad_size;

      slot_in   = slot_ff;
      seen_in   = seen_ff;
      failed_in = failed_ff;
      if (fire) begin
         if (in_last_ff) begin
            // verdict goes out, log starts over
            slot_in   = '0;
            seen_in   = '0;
            failed_in = 1'b0;
         end else begin
            failed_in = failed_next;
            if (closing) begin
               slot_in = '0;
               seen_in = '0;
            end else begin
               slot_in = slot_ff + IDX_W'(1);
               seen_in = eff_seen | rank_onehot;
            end
         end
      end

      if (req_xfer) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end

      if (fire && in_last_ff) begin
         out_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         slot_ff    <= '0;
         seen_ff    <= '0;
         failed_ff  <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         slot_ff    <= slot_in;
         seen_ff    <= seen_in;
         failed_ff  <= failed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_rank_ff  <= req_ch.rank;
         in_seq_ff   <= req_ch.sequence_req;
         in_bytes_ff <= req_ch.byte_count;
         in_begin_ff <= req_ch.is_begin;
         in_last_ff  <= req_ch.last_entry;
      end
      if (fire && first) begin
         ref_seq_ff   <= in_seq_ff;
         ref_bytes_ff <= in_bytes_ff;
         ref_begin_ff <= in_begin_ff;
      end
      if (fire && in_last_ff) begin
         out_consistent_ff <= verdict;
      end
   end

   assign rsp_ch.valid      = out_vld_ff;
   assign rsp_ch.consistent = out_consistent_ff;

endmodule
